[hw/rtl/rwp_pkg.sv]
// ----------------------------------------------------------------------------
// RIFF/WAVE header parser package
// Shared types, status codes, parse phases and tag constants.
// ----------------------------------------------------------------------------
package rwp_pkg;

    localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE    = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT     = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [31:0] FMT_GAP     = 32'd6;
    localparam logic [31:0] RIFF_SIZE_BYTES = 32'd4;

    typedef enum logic [3:0] {
        PH_RIFF       = 4'd0,
        PH_SKIP_SIZE  = 4'd1,
        PH_WAVE       = 4'd2,
        PH_TAG        = 4'd3,
        PH_FMT_LEN    = 4'd4,
        PH_FMT_PCM    = 4'd5,
        PH_FMT_CH     = 4'd6,
        PH_FMT_RATE   = 4'd7,
        PH_SKIP_GAP   = 4'd8,
        PH_FMT_BITS   = 4'd9,
        PH_CHUNK_LEN  = 4'd10,
        PH_SKIP_CHUNK = 4'd11,
        PH_DATA_LEN   = 4'd12
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_RIFF     = 3'd1,
        ST_BAD_WAVE     = 3'd2,
        ST_FMT_SHORT    = 3'd3,
        ST_NOT_PCM      = 3'd4,
        ST_BAD_CHANNELS = 3'd5,
        ST_BAD_BITS     = 3'd6,
        ST_TRUNCATED    = 3'd7
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [1:0]  channel_count;
        logic [31:0] sample_rate;
        logic [4:0]  bits_per_sample;
        logic [2:0]  frame_bytes;
        logic [31:0] sample_count;
        logic [31:0] data_offset;
    } t_result;

endpackage

[hw/rtl/rwp_core.sv]
// ----------------------------------------------------------------------------
// RIFF/WAVE header parser core
// Holds the parse state and works out the next state and any result for one
// word combinationally.
// ----------------------------------------------------------------------------
module rwp_core
    import rwp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_of_file,
    input  logic       i_last_of_file,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase,    n_phase,    c_phase;
    logic [1:0]  r_idx,      n_idx,      c_idx;
    logic [31:0] r_shift,    n_shift,    c_shift;
    logic [31:0] r_fmt_len,  n_fmt_len,  c_fmt_len;
    logic [31:0] r_skip,     n_skip,     c_skip;
    logic [31:0] r_pos,      n_pos,      c_pos;
    logic [1:0]  r_channels, n_channels, c_channels;
    logic [4:0]  r_bits,     n_bits,     c_bits;
    logic [31:0] r_rate,     n_rate,     c_rate;
    logic        r_finished, n_finished, c_finished;

    always_comb begin
        if (i_first_of_file) begin
            c_phase    = PH_RIFF;
            c_idx      = '0;
            c_shift    = '0;
            c_fmt_len  = '0;
            c_skip     = '0;
            c_pos      = '0;
            c_channels = '0;
            c_bits     = '0;
            c_rate     = '0;
            c_finished = 1'b0;
        end else begin
            c_phase    = r_phase;
            c_idx      = r_idx;
            c_shift    = r_shift;
            c_fmt_len  = r_fmt_len;
            c_skip     = r_skip;
            c_pos      = r_pos;
            c_channels = r_channels;
            c_bits     = r_bits;
            c_rate     = r_rate;
            c_finished = r_finished;
        end
    end

    logic [31:0] v;
    logic [31:0] skip_dec;
    logic [31:0] fmt_excess;
    logic [32:0] stereo_len;
    logic [31:0] frames;
    logic [6:0]  frame_prod;
    logic        gather_two;
    logic        gather_done;
    logic        gathering;
    logic        err;
    logic        ok;
    t_status     err_code;

    always_comb begin
        v          = c_shift | ({24'b0, i_data_byte} << {c_idx, 3'b000});
        skip_dec   = c_skip - 32'd1;
        fmt_excess = c_fmt_len - FMT_MIN_LEN;
        gather_two = (c_phase == PH_FMT_PCM) || (c_phase == PH_FMT_CH) ||
                     (c_phase == PH_FMT_BITS);
        gather_done = gather_two ? (c_idx != 2'd0) : (c_idx == 2'd3);
        gathering  = (c_phase == PH_RIFF) || (c_phase == PH_WAVE) ||
                     (c_phase == PH_TAG) || (c_phase == PH_FMT_LEN) ||
                     (c_phase == PH_FMT_RATE) || (c_phase == PH_CHUNK_LEN) ||
                     (c_phase == PH_DATA_LEN) || gather_two;
        stereo_len = ({1'b0, v} + 33'd1) >> 1;
        frames     = (c_channels == 2'd2) ? stereo_len[31:0] : v;
        if (c_bits == 5'd16) begin
            frames = frames >> 1;
        end
        frame_prod = {5'b0, c_channels} * {2'b0, c_bits};

        n_phase    = c_phase;
        n_idx      = c_idx;
        n_shift    = c_shift;
        n_fmt_len  = c_fmt_len;
        n_skip     = c_skip;
        n_pos      = c_pos;
        n_channels = c_channels;
        n_bits     = c_bits;
        n_rate     = c_rate;
        n_finished = c_finished;
        err        = 1'b0;
        ok         = 1'b0;
        err_code   = ST_OK;
        o_res_valid = 1'b0;
        o_res      = '0;

        if (!c_finished) begin
            if (c_pos != 32'hFFFF_FFFF) begin
                n_pos = c_pos + 32'd1;
            end
            if (gathering) begin
                if (gather_done) begin
                    n_shift = '0;
                    n_idx   = '0;
                end else begin
                    n_shift = v;
                    n_idx   = c_idx + 2'd1;
                end
            end
            case (c_phase)
                PH_RIFF: begin
                    if (gather_done) begin
                        if (v != TAG_RIFF) begin
                            err = 1'b1; err_code = ST_BAD_RIFF;
                        end else begin
                            n_skip  = RIFF_SIZE_BYTES;
                            n_phase = PH_SKIP_SIZE;
                        end
                    end
                end
                PH_SKIP_SIZE: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) n_phase = PH_WAVE;
                end
                PH_WAVE: begin
                    if (gather_done) begin
                        if (v != TAG_WAVE) begin
                            err = 1'b1; err_code = ST_BAD_WAVE;
                        end else begin
                            n_phase = PH_TAG;
                        end
                    end
                end
                PH_TAG: begin
                    if (gather_done) begin
                        if (v == TAG_FMT) n_phase = PH_FMT_LEN;
                        else if (v == TAG_DATA) n_phase = PH_DATA_LEN;
                        else n_phase = PH_CHUNK_LEN;
                    end
                end
                PH_FMT_LEN: begin
                    if (gather_done) begin
                        if (v[31] || (v < FMT_MIN_LEN)) begin
                            err = 1'b1; err_code = ST_FMT_SHORT;
                        end else begin
                            n_fmt_len = v;
                            n_phase   = PH_FMT_PCM;
                        end
                    end
                end
                PH_FMT_PCM: begin
                    if (gather_done) begin
                        if (v != 32'd1) begin
                            err = 1'b1; err_code = ST_NOT_PCM;
                        end else begin
                            n_phase = PH_FMT_CH;
                        end
                    end
                end
                PH_FMT_CH: begin
                    if (gather_done) begin
                        if ((v != 32'd1) && (v != 32'd2)) begin
                            err = 1'b1; err_code = ST_BAD_CHANNELS;
                        end else begin
                            n_channels = v[1:0];
                            n_phase    = PH_FMT_RATE;
                        end
                    end
                end
                PH_FMT_RATE: begin
                    if (gather_done) begin
                        n_rate  = v;
                        n_skip  = FMT_GAP;
                        n_phase = PH_SKIP_GAP;
                    end
                end
                PH_SKIP_GAP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) n_phase = PH_FMT_BITS;
                end
                PH_FMT_BITS: begin
                    if (gather_done) begin
                        if ((v != 32'd8) && (v != 32'd16)) begin
                            err = 1'b1; err_code = ST_BAD_BITS;
                        end else begin
                            n_bits = v[4:0];
                            if (fmt_excess == '0) begin
                                n_phase = PH_TAG;
                            end else begin
                                n_skip  = fmt_excess;
                                n_phase = PH_SKIP_CHUNK;
                            end
                        end
                    end
                end
                PH_CHUNK_LEN: begin
                    if (gather_done) begin
                        if (v == '0) begin
                            n_phase = PH_TAG;
                        end else begin
                            n_skip  = v;
                            n_phase = PH_SKIP_CHUNK;
                        end
                    end
                end
                PH_SKIP_CHUNK: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) n_phase = PH_TAG;
                end
                PH_DATA_LEN: begin
                    if (gather_done) begin
                        ok = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_RIFF;
                end
            endcase

            if (ok) begin
                n_finished            = 1'b1;
                o_res_valid           = 1'b1;
                o_res.status          = ST_OK;
                o_res.channel_count   = c_channels;
                o_res.sample_rate     = c_rate;
                o_res.bits_per_sample = c_bits;
                o_res.frame_bytes     = frame_prod[5:3];
                o_res.sample_count    = frames;
                o_res.data_offset     = n_pos;
            end else if (err || i_last_of_file) begin
                n_finished   = 1'b1;
                o_res_valid  = 1'b1;
                o_res.status = err ? err_code : ST_TRUNCATED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF;
            r_idx      <= '0;
            r_shift    <= '0;
            r_fmt_len  <= '0;
            r_skip     <= '0;
            r_pos      <= '0;
            r_channels <= '0;
            r_bits     <= '0;
            r_rate     <= '0;
            r_finished <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_shift    <= n_shift;
            r_fmt_len  <= n_fmt_len;
            r_skip     <= n_skip;
            r_pos      <= n_pos;
            r_channels <= n_channels;
            r_bits     <= n_bits;
            r_rate     <= n_rate;
            r_finished <= n_finished;
        end
    end

endmodule

[hw/rtl/riff_wave_header_parser.sv]
// ----------------------------------------------------------------------------
// RIFF/WAVE header parser
// A word passes the input register, then the parse step, then the result register.
// Throughput: one word per cycle, unless a held result stalls the output.
// Reset: synchronous, active low; parsing restarts at byte 0 of a file.
// ----------------------------------------------------------------------------
module riff_wave_header_parser
    import rwp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_file,
    input  logic        i_last_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [1:0]  o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [4:0]  o_bits_per_sample,
    output logic [2:0]  o_frame_bytes,
    output logic [31:0] o_sample_count,
    output logic [31:0] o_data_offset
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    logic       can_adv;
    logic       consume;
    logic       accept;
    logic       res_valid;
    t_result    res;

    assign can_adv = !r_out_valid || !i_stall;
    assign consume = r_in_valid && can_adv;
    assign o_stall = r_in_valid && !can_adv;
    assign accept  = i_valid && !o_stall;

    rwp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (consume),
        .i_data_byte     (r_in_byte),
        .i_first_of_file (r_in_first),
        .i_last_of_file  (r_in_last),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_of_file;
            r_in_last  <= i_last_of_file;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume) begin
            r_out_valid <= res_valid;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out.status;
    assign o_channel_count   = r_out.channel_count;
    assign o_sample_rate     = r_out.sample_rate;
    assign o_bits_per_sample = r_out.bits_per_sample;
    assign o_frame_bytes     = r_out.frame_bytes;
    assign o_sample_count    = r_out.sample_count;
    assign o_data_offset     = r_out.data_offset;

endmodule

[tb/tb_riff_wave_header_parser.sv]
// ----------------------------------------------------------------------------
// RIFF/WAVE header parser testbench
// Feeds whole and damaged WAV files into the parser one byte per word, with
// random gaps on the input and random stalls on the output. A scoreboard
// class parses each accepted byte itself and checks every header result,
// field by field and in order, against what it worked out.
// ----------------------------------------------------------------------------
import rwp_pkg::*;

typedef logic [7:0] t_octet;

class wav_scoreboard;
    t_phase      phase;
    logic [1:0]  fidx;
    logic [31:0] shift;
    logic [31:0] word_val;
    logic [31:0] fmt_len;
    logic [31:0] skip_cnt;
    logic [31:0] pos;
    logic [31:0] rate;
    logic [1:0]  chans;
    logic [4:0]  bits;
    bit          done;
    t_result     expected_headers[$];
    int          headers_due;
    int          errors_due;
    int          checked;
    int          fails;

    function new();
        restart();
        headers_due = 0;
        errors_due  = 0;
        checked     = 0;
        fails       = 0;
    endfunction

    function void restart();
        phase    = PH_RIFF;
        fidx     = '0;
        shift    = '0;
        word_val = '0;
        fmt_len  = '0;
        skip_cnt = '0;
        pos      = '0;
        rate     = '0;
        chans    = '0;
        bits     = '0;
        done     = 1'b0;
    endfunction

    // Collects little-endian bytes; true once nbytes have been gathered.
    function bit gather(t_octet b, int nbytes);
        shift |= 32'(b) << (8 * fidx);
        if (int'(fidx) + 1 >= nbytes) begin
            word_val = shift;
            shift    = '0;
            fidx     = '0;
            return 1'b1;
        end
        fidx = fidx + 2'd1;
        return 1'b0;
    endfunction

    function void enter_skip(logic [31:0] count, t_phase skip_ph, t_phase target);
        if (count == 32'd0) begin
            phase = target;
        end else begin
            skip_cnt = count;
            phase    = skip_ph;
        end
    endfunction

    function void skip_one(t_phase target);
        skip_cnt = skip_cnt - 32'd1;
        if (skip_cnt == 32'd0) begin
            phase = target;
        end
    endfunction

    function void post_error(t_status st);
        t_result r;
        r        = '0;
        r.status = st;
        expected_headers.push_back(r);
        headers_due++;
        errors_due++;
        done = 1'b1;
    endfunction

    function void parse_byte(t_octet b, bit is_first, bit is_last);
        t_result     r;
        logic [32:0] n;
        if (is_first) begin
            restart();
        end
        if (done) begin
            return;
        end
        if (pos != 32'hFFFF_FFFF) begin
            pos = pos + 32'd1;
        end
        case (phase)
            PH_RIFF: begin
                if (gather(b, 4)) begin
                    if (word_val != TAG_RIFF) begin
                        post_error(ST_BAD_RIFF);
                        return;
                    end
                    enter_skip(RIFF_SIZE_BYTES, PH_SKIP_SIZE, PH_WAVE);
                end
            end
            PH_SKIP_SIZE: skip_one(PH_WAVE);
            PH_WAVE: begin
                if (gather(b, 4)) begin
                    if (word_val != TAG_WAVE) begin
                        post_error(ST_BAD_WAVE);
                        return;
                    end
                    phase = PH_TAG;
                end
            end
            PH_TAG: begin
                if (gather(b, 4)) begin
                    if (word_val == TAG_FMT) begin
                        phase = PH_FMT_LEN;
                    end else if (word_val == TAG_DATA) begin
                        phase = PH_DATA_LEN;
                    end else begin
                        phase = PH_CHUNK_LEN;
                    end
                end
            end
            PH_FMT_LEN: begin
                if (gather(b, 4)) begin
                    if (word_val[31] || word_val < FMT_MIN_LEN) begin
                        post_error(ST_FMT_SHORT);
                        return;
                    end
                    fmt_len = word_val;
                    phase   = PH_FMT_PCM;
                end
            end
            PH_FMT_PCM: begin
                if (gather(b, 2)) begin
                    if (word_val != 32'd1) begin
                        post_error(ST_NOT_PCM);
                        return;
                    end
                    phase = PH_FMT_CH;
                end
            end
            PH_FMT_CH: begin
                if (gather(b, 2)) begin
                    if (word_val != 32'd1 && word_val != 32'd2) begin
                        post_error(ST_BAD_CHANNELS);
                        return;
                    end
                    chans = word_val[1:0];
                    phase = PH_FMT_RATE;
                end
            end
            PH_FMT_RATE: begin
                if (gather(b, 4)) begin
                    rate = word_val;
                    enter_skip(FMT_GAP, PH_SKIP_GAP, PH_FMT_BITS);
                end
            end
            PH_SKIP_GAP: skip_one(PH_FMT_BITS);
            PH_FMT_BITS: begin
                if (gather(b, 2)) begin
                    if (word_val != 32'd8 && word_val != 32'd16) begin
                        post_error(ST_BAD_BITS);
                        return;
                    end
                    bits = word_val[4:0];
                    enter_skip(fmt_len - FMT_MIN_LEN, PH_SKIP_CHUNK, PH_TAG);
                end
            end
            PH_CHUNK_LEN: begin
                if (gather(b, 4)) begin
                    enter_skip(word_val, PH_SKIP_CHUNK, PH_TAG);
                end
            end
            PH_SKIP_CHUNK: skip_one(PH_TAG);
            PH_DATA_LEN: begin
                if (gather(b, 4)) begin
                    n = {1'b0, word_val};
                    if (chans == 2'd2) begin
                        n = (n + 33'd1) / 33'd2;
                    end
                    if (bits == 5'd16) begin
                        n = n / 33'd2;
                    end
                    r.status          = ST_OK;
                    r.channel_count   = chans;
                    r.sample_rate     = rate;
                    r.bits_per_sample = bits;
                    r.frame_bytes     = 3'((int'(chans) * int'(bits)) / 8);
                    r.sample_count    = n[31:0];
                    r.data_offset     = pos;
                    expected_headers.push_back(r);
                    headers_due++;
                    done = 1'b1;
                    return;
                end
            end
            default: phase = PH_RIFF;
        endcase
        if (is_last) begin
            post_error(ST_TRUNCATED);
        end
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fails++;
    endtask

    task chk(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report($sformatf("header %0d %s: got 0x%08h, expected 0x%08h",
                             checked, name, got, want));
        end
    endtask

    task check_header(t_result got);
        t_result want;
        checked++;
        if (expected_headers.size() == 0) begin
            report($sformatf("header %0d arrived with none expected, status %0d",
                             checked, got.status));
            return;
        end
        want = expected_headers.pop_front();
        chk("status", 32'(got.status), 32'(want.status));
        chk("channel_count", 32'(got.channel_count), 32'(want.channel_count));
        chk("sample_rate", got.sample_rate, want.sample_rate);
        chk("bits_per_sample", 32'(got.bits_per_sample), 32'(want.bits_per_sample));
        chk("frame_bytes", 32'(got.frame_bytes), 32'(want.frame_bytes));
        chk("sample_count", got.sample_count, want.sample_count);
        chk("data_offset", got.data_offset, want.data_offset);
    endtask

    task wrap_up();
        if (expected_headers.size() != 0) begin
            report($sformatf("%0d expected headers never arrived",
                             expected_headers.size()));
        end
    endtask
endclass

module tb_riff_wave_header_parser;

    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_first_of_file;
    logic        i_last_of_file;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [1:0]  o_channel_count;
    logic [31:0] o_sample_rate;
    logic [4:0]  o_bits_per_sample;
    logic [2:0]  o_frame_bytes;
    logic [31:0] o_sample_count;
    logic [31:0] o_data_offset;

    wav_scoreboard sb;
    t_octet        wav_q[$];
    int            bytes_sent;
    int            files_sent;
    bit            calm;

    riff_wave_header_parser u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_first_of_file   (i_first_of_file),
        .i_last_of_file    (i_last_of_file),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_channel_count   (o_channel_count),
        .o_sample_rate     (o_sample_rate),
        .o_bits_per_sample (o_bits_per_sample),
        .o_frame_bytes     (o_frame_bytes),
        .o_sample_count    (o_sample_count),
        .o_data_offset     (o_data_offset)
    );

    always #6 i_clk = ~i_clk;

    function automatic void put8(logic [7:0] v);
        wav_q.push_back(v);
    endfunction

    function automatic void put16(logic [15:0] v);
        put8(v[7:0]);
        put8(v[15:8]);
    endfunction

    function automatic void put32(logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endfunction

    function automatic void put_head(logic [31:0] riff, logic [31:0] wave);
        put32(riff);
        put32($urandom);
        put32(wave);
    endfunction

    function automatic void put_fmt(logic [31:0] len, logic [15:0] code, logic [15:0] ch,
                                    logic [31:0] rate, logic [15:0] bits);
        put32(TAG_FMT);
        put32(len);
        put16(code);
        put16(ch);
        put32(rate);
        repeat (6) put8(8'($urandom));
        put16(bits);
        if (len >= FMT_MIN_LEN && len <= 32'd40) begin
            repeat (int'(len - FMT_MIN_LEN)) put8(8'($urandom));
        end
    endfunction

    function automatic void put_junk(logic [31:0] len);
        logic [31:0] tag;
        do tag = $urandom; while (tag == TAG_FMT || tag == TAG_DATA);
        put32(tag);
        put32(len);
        if (len <= 32'd64) begin
            repeat (int'(len)) put8(8'($urandom));
        end
    endfunction

    function automatic void put_data(logic [31:0] len, int extra);
        put32(TAG_DATA);
        put32(len);
        repeat (extra) put8(8'($urandom));
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd44100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_data_len();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_FFFE;
            3: return 32'($urandom_range(1, 9));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_junk_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return 32'($urandom_range(0, 6));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(t_octet b, bit is_first, bit is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_first_of_file <= is_first;
        i_last_of_file  <= is_last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.parse_byte(b, is_first, is_last);
        bytes_sent++;
    endtask

    // Sends the first keep bytes of the file built up (all of it when keep < 0).
    task automatic send_wav(bit first_flag, bit last_flag, int keep);
        int n;
        n = (keep < 0 || keep > wav_q.size()) ? wav_q.size() : keep;
        for (int k = 0; k < n; k++) begin
            send_byte(wav_q[k], first_flag && k == 0, last_flag && k == n - 1);
        end
        wav_q.delete();
        files_sent++;
    endtask

    task automatic random_wav();
        int          kind;
        int          nf;
        logic [31:0] riff;
        logic [31:0] wave;
        logic [31:0] flen;
        logic [15:0] code;
        logic [15:0] ch;
        logic [15:0] bits;
        kind = $urandom_range(0, 99);
        calm = ($urandom_range(0, 9) == 0);
        if (kind >= 95) begin
            repeat ($urandom_range(1, 20)) put8(8'($urandom));
            send_wav(1'b1, 1'($urandom_range(0, 1)), -1);
            return;
        end
        riff = TAG_RIFF;
        wave = TAG_WAVE;
        flen = FMT_MIN_LEN + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
        code = 16'd1;
        ch   = 16'($urandom_range(1, 2));
        bits = ($urandom_range(0, 1) != 0) ? 16'd16 : 16'd8;
        if (kind >= 70 && kind < 85) begin
            case ($urandom_range(0, 5))
                0: riff ^= 32'd1 << $urandom_range(0, 31);
                1: wave ^= 32'd1 << $urandom_range(0, 31);
                2: flen = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 15))
                                                      : ($urandom | 32'h8000_0000);
                3: do code = 16'($urandom); while (code == 16'd1);
                4: do ch = 16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom);
                   while (ch == 16'd1 || ch == 16'd2);
                default: do bits = 16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 31)
                                                                   : $urandom);
                         while (bits == 16'd8 || bits == 16'd16);
            endcase
        end
        nf = (kind < 70 && $urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
        put_head(riff, wave);
        repeat ($urandom_range(0, 2)) put_junk(pick_junk_len());
        if (nf == 2) begin
            put_fmt(FMT_MIN_LEN, 16'd1, 16'($urandom_range(1, 2)), pick_rate(),
                    ($urandom_range(0, 1) != 0) ? 16'd16 : 16'd8);
        end
        if (nf > 0) begin
            put_fmt(flen, code, ch, pick_rate(), bits);
        end
        if ($urandom_range(0, 3) == 0) begin
            put_junk(32'($urandom_range(0, 6)));
        end
        put_data(pick_data_len(), $urandom_range(0, 3));
        if (kind >= 85) begin
            send_wav(1'b1, $urandom_range(0, 4) != 0, $urandom_range(1, wav_q.size()));
        end else begin
            send_wav($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), -1);
        end
    endtask

    initial begin : sink
        t_result seen;
        int      hold;
        int      r;
        hold = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                seen.status          = t_status'(o_status);
                seen.channel_count   = o_channel_count;
                seen.sample_rate     = o_sample_rate;
                seen.bits_per_sample = o_bits_per_sample;
                seen.frame_bytes     = o_frame_bytes;
                seen.sample_count    = o_sample_count;
                seen.data_offset     = o_data_offset;
                sb.check_header(seen);
            end
            if (calm) begin
                i_stall <= 1'b0;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    i_stall <= 1'b0;
                    hold = $urandom_range(0, 15);
                end else if (r < 92) begin
                    i_stall <= 1'b1;
                    hold = $urandom_range(0, 3);
                end else begin
                    i_stall <= 1'b1;
                    hold = $urandom_range(10, 50);
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) ||
                (o_valid === 1'b1 && i_stall === 1'b0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_data_byte     <= '0;
        i_first_of_file <= 1'b0;
        i_last_of_file  <= 1'b0;
        calm            = 1'b1;
        bytes_sent      = 0;
        files_sent      = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first file after reset goes in without the start flag; the bytes
        // that follow its result must be ignored, the last-byte flag included.
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd1, 32'd8000, 16'd8);
        put_data(32'd0, 2);
        send_wav(1'b0, 1'b0, -1);
        repeat (3) put8(8'($urandom));
        send_wav(1'b0, 1'b1, -1);
        calm = 1'b0;

        // The last byte of the data length completes the header, so it is no truncation.
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd2, 32'd44100, 16'd16);
        put_data(32'hFFFF_FFFF, 0);
        send_wav(1'b1, 1'b1, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd2, 32'hFFFF_FFFF, 16'd8);
        put_data(32'hFFFF_FFFF, 1);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd18, 16'd1, 16'd1, 32'd0, 16'd16);
        put_junk(32'd0);
        put_junk(32'd3);
        put_data(32'd1, 0);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd2, 32'd48000, 16'd16);
        put_data(32'd3, 0);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_data(32'h1234_5678, 0);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd1, 32'd8000, 16'd8);
        put_fmt(32'd20, 16'd1, 16'd2, 32'd22050, 16'd16);
        put_data(32'd100, 0);
        send_wav(1'b1, 1'b0, -1);

        // Format errors; the bad RIFF tag ends on the last byte of its file.
        put_head(TAG_RIFF ^ 32'd1, TAG_WAVE);
        send_wav(1'b1, 1'b1, 4);
        put_head(TAG_RIFF, TAG_WAVE ^ 32'h100);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd15, 16'd1, 16'd1, 32'd8000, 16'd8);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'h8000_0010, 16'd1, 16'd1, 32'd8000, 16'd8);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd3, 16'd1, 32'd8000, 16'd8);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd0, 32'd8000, 16'd8);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd3, 32'd8000, 16'd8);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd1, 32'd8000, 16'd24);
        send_wav(1'b1, 1'b0, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd2, 32'd8000, 16'd0);
        send_wav(1'b1, 1'b0, -1);

        // Early ends, a one-byte file and a restart in the middle of a file.
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd1, 32'd8000, 16'd8);
        send_wav(1'b1, 1'b1, 25);
        put8(8'hA5);
        send_wav(1'b1, 1'b1, -1);
        put_head(TAG_RIFF, TAG_WAVE);
        send_wav(1'b1, 1'b0, 10);
        put_head(TAG_RIFF, TAG_WAVE);
        put_fmt(32'd16, 16'd1, 16'd1, 32'd11025, 16'd16);
        put_data(32'd7, 0);
        send_wav(1'b1, 1'b0, -1);

        while (bytes_sent < 1100) begin
            random_wav();
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (sb.expected_headers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        sb.wrap_up();
        $display("Run covered %0d bytes in %0d files, with %0d headers expected,",
                 bytes_sent, files_sent, sb.headers_due);
        $display("%0d of them errors, and %0d headers checked.",
                 sb.errors_due, sb.checked);
        if (sb.fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rwp_pkg.sv
hw/rtl/rwp_core.sv
hw/rtl/riff_wave_header_parser.sv
tb/tb_riff_wave_header_parser.sv
